>>> sv/fragment_frame_reassembler_macros.svh
// Assertion macros shared by the reassembler modules.
`ifndef FRAGMENT_FRAME_REASSEMBLER_MACROS_SVH
`define FRAGMENT_FRAME_REASSEMBLER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FFR_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("reassembler check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FFR_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("reassembler check failed");

`endif

>>> sv/ffr_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package ffr_pkg;

  localparam int MAX_PENDING  = 4;
  localparam int MAX_ENTITIES = 64;
  localparam int ENTITY_BITS  = 64;
  localparam int NSLOTS       = MAX_PENDING + 1;
  localparam int SLOT_W       = $clog2(NSLOTS);
  localparam int IDX_W        = 6;
  localparam int ADDR_W       = $clog2(NSLOTS * MAX_ENTITIES);
  localparam int IN_DATA_W    = 136;
  localparam int OUT_DATA_W   = 112;

  localparam logic [1:0] STAT_PENDING      = 2'd0;
  localparam logic [1:0] STAT_STALE        = 2'd1;
  localparam logic [1:0] STAT_INCONSISTENT = 2'd2;
  localparam logic [1:0] STAT_COMPLETED    = 2'd3;

  typedef struct packed {
    logic take;    // latch the accepted item
    logic hdr;     // set up the batch from its first item
    logic ent;     // store the item's entity
    logic finish;  // decide the batch result
    logic rd;      // read one stored entity
    logic emit;    // present one stored entity
  } cmd_t;

  typedef struct packed {
    logic batch_open;
    logic item_end;
    logic emit_many;
    logic out_free;
    logic em_last;
  } sts_t;

endpackage

>>> sv/fragment_frame_reassembler.sv
// Top level of the fragment frame reassembler: controller plus datapath.
// Frames arrive as batches of entity items, one item per handshake; the first
// item of a batch sets up a slot for its tick (five slots), later items fill
// the slot's bitmap and entity store. On the last item of a batch the block
// returns one status item (pending, stale dropped or inconsistent dropped) or,
// once the frame is complete, every entity in index order. An item that does
// not end its batch passes the input and entity states (the first item of a
// batch also passes the header state for the slot lookup). A batch end adds
// a decision state, and a completed frame streams each entity through a read
// and an emit state, for the registered store read. The result register lets
// a waiting result stand while the next item is taken.
module fragment_frame_reassembler (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // frame_tick, frame_total, frame_phase, batch_first_index,
  // batch_position, entity_word, zero pad
  input  logic [ffr_pkg::IN_DATA_W-1:0]  s_tdata,
  // has_entity
  input  logic                           s_tuser,
  // batch_end
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_tick, out_phase, out_index, out_entity, zero pad
  output logic [ffr_pkg::OUT_DATA_W-1:0] m_tdata,
  // status, out_valid_entity
  output logic [2:0]                     m_tuser,
  // last_of_run
  output logic                           m_tlast
);

  ffr_pkg::cmd_t cmd;
  ffr_pkg::sts_t sts;

  ffr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> sv/ffr_ctrl.sv
// Controller state machine sequencing header, entity, result and emission steps.
module ffr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  ffr_pkg::sts_t  sts,
  output ffr_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IN   = 6'b000001,
    ST_HDR  = 6'b000010,
    ST_ENT  = 6'b000100,
    ST_FIN  = 6'b001000,
    ST_RD   = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IN: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = sts.batch_open ? ST_ENT : ST_HDR;
        end
      end
      ST_HDR: begin
        cmd.hdr    = 1'b1;
        state_next = ST_ENT;
      end
      ST_ENT: begin
        cmd.ent    = 1'b1;
        state_next = sts.item_end ? ST_FIN : ST_IN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = sts.emit_many ? ST_RD : ST_IN;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.em_last ? ST_IN : ST_RD;
        end
      end
      default: begin
        state_next = ST_IN;
      end
    endcase
  end

endmodule

>>> sv/ffr_datapath.sv
// Datapath: slot table, entity store, batch state and the result register.
`include "fragment_frame_reassembler_macros.svh"

module ffr_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [ffr_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tuser,
  input  logic                             s_tlast,
  input  ffr_pkg::cmd_t                    cmd,
  output ffr_pkg::sts_t                    sts,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ffr_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [2:0]                       m_tuser,
  output logic                             m_tlast
);

  // Latched item.
  logic [31:0]                    it_tick;
  logic [6:0]                     it_total;
  logic [7:0]                     it_phase;
  logic [15:0]                    it_first;
  logic [5:0]                     it_pos;
  logic                           it_has;
  logic [ffr_pkg::ENTITY_BITS-1:0] it_word;
  logic                           it_end;

  // Slot table.
  logic [ffr_pkg::NSLOTS-1:0]       slot_used;
  logic [31:0]                      slot_tick   [ffr_pkg::NSLOTS];
  logic [6:0]                       slot_total  [ffr_pkg::NSLOTS];
  logic [7:0]                       slot_phase  [ffr_pkg::NSLOTS];
  logic [6:0]                       slot_count  [ffr_pkg::NSLOTS];
  logic [ffr_pkg::MAX_ENTITIES-1:0] slot_bitmap [ffr_pkg::NSLOTS];

  logic [ffr_pkg::ENTITY_BITS-1:0] entity_store [ffr_pkg::NSLOTS * ffr_pkg::MAX_ENTITIES];
  logic [ffr_pkg::ENTITY_BITS-1:0] rd_data;

  logic [31:0]                newest_done_tick;
  logic                       any_done;
  logic                       batch_open;
  logic [1:0]                 batch_discard;
  logic [ffr_pkg::SLOT_W-1:0] batch_slot;

  // Emission walk.
  logic [31:0]                em_tick;
  logic [7:0]                 em_phase;
  logic [6:0]                 em_n;
  logic [ffr_pkg::IDX_W-1:0]  em_i;
  logic [ffr_pkg::SLOT_W-1:0] em_slot;

  // Result register.
  logic        o_valid;
  logic [1:0]  o_status;
  logic [31:0] o_tick;
  logic [7:0]  o_phase;
  logic [5:0]  o_index;
  logic        o_vent;
  logic [63:0] o_entity;
  logic        o_last;

  logic out_free;
  assign out_free = !o_valid || m_tready;

  // Slot lookup by tick, first free slot, oldest slot.
  logic                       hit_found, free_found, old_found;
  logic [ffr_pkg::SLOT_W-1:0] hit_slot, free_slot, old_slot;
  always_comb begin
    hit_found  = 1'b0;
    hit_slot   = '0;
    free_found = 1'b0;
    free_slot  = '0;
    old_found  = 1'b0;
    old_slot   = '0;
    for (int k = 0; k < ffr_pkg::NSLOTS; k++) begin
      if (!hit_found && slot_used[k] && slot_tick[k] == it_tick) begin
        hit_found = 1'b1;
        hit_slot  = ffr_pkg::SLOT_W'(k);
      end
      if (!free_found && !slot_used[k]) begin
        free_found = 1'b1;
        free_slot  = ffr_pkg::SLOT_W'(k);
      end
      if (slot_used[k] && (!old_found || slot_tick[k] < slot_tick[old_slot])) begin
        old_found = 1'b1;
        old_slot  = ffr_pkg::SLOT_W'(k);
      end
    end
  end

  // Entity placement for the current batch slot.
  logic [16:0]               idx;
  logic [ffr_pkg::IDX_W-1:0] idx_lo;
  logic                      ent_ok;
  logic [ffr_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  assign idx    = 17'(it_first) + 17'(it_pos);
  assign idx_lo = idx[ffr_pkg::IDX_W-1:0];
  assign ent_ok = batch_discard == ffr_pkg::STAT_PENDING && it_has
                  && idx < 17'(slot_total[batch_slot])
                  && idx < 17'(ffr_pkg::MAX_ENTITIES)
                  && !slot_bitmap[batch_slot][idx_lo];
  assign wr_addr = ffr_pkg::ADDR_W'(batch_slot) * ffr_pkg::ADDR_W'(ffr_pkg::MAX_ENTITIES)
                   + ffr_pkg::ADDR_W'(idx_lo);
  assign rd_addr = ffr_pkg::ADDR_W'(em_slot) * ffr_pkg::ADDR_W'(ffr_pkg::MAX_ENTITIES)
                   + ffr_pkg::ADDR_W'(em_i);

  logic complete;
  assign complete = slot_count[batch_slot] >= slot_total[batch_slot];

  assign sts.batch_open = batch_open;
  assign sts.item_end   = it_end;
  assign sts.emit_many  = batch_discard == ffr_pkg::STAT_PENDING && complete
                          && slot_total[batch_slot] != 7'd0;
  assign sts.out_free   = out_free;
  assign sts.em_last    = (7'(em_i) + 7'd1) == em_n;

  always_ff @(posedge clk) begin
    if (cmd.ent && ent_ok) begin
      entity_store[wr_addr] <= it_word;
    end
    if (cmd.rd) begin
      rd_data <= entity_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      it_tick  <= s_tdata[31:0];
      it_total <= s_tdata[38:32];
      it_phase <= s_tdata[46:39];
      it_first <= s_tdata[62:47];
      it_pos   <= s_tdata[68:63];
      it_word  <= s_tdata[69 +: ffr_pkg::ENTITY_BITS];
      it_has   <= s_tuser;
      it_end   <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used        <= '0;
      newest_done_tick <= '0;
      any_done         <= 1'b0;
      batch_open       <= 1'b0;
      batch_discard    <= ffr_pkg::STAT_PENDING;
      batch_slot       <= '0;
      o_valid          <= 1'b0;
      for (int k = 0; k < ffr_pkg::NSLOTS; k++) begin
        slot_tick[k]   <= '0;
        slot_total[k]  <= '0;
        slot_phase[k]  <= '0;
        slot_count[k]  <= '0;
        slot_bitmap[k] <= '0;
      end
    end else begin
      if (m_tready) begin
        o_valid <= 1'b0;
      end
      if (cmd.hdr) begin
        batch_open    <= 1'b1;
        batch_discard <= ffr_pkg::STAT_PENDING;
        if (any_done && it_tick <= newest_done_tick) begin
          if (hit_found) begin
            slot_used[hit_slot] <= 1'b0;
          end
          batch_discard <= ffr_pkg::STAT_STALE;
        end else if (!hit_found) begin
          slot_used[free_slot]   <= 1'b1;
          slot_tick[free_slot]   <= it_tick;
          slot_total[free_slot]  <= it_total;
          slot_phase[free_slot]  <= it_phase;
          slot_count[free_slot]  <= '0;
          slot_bitmap[free_slot] <= '0;
          batch_slot             <= free_slot;
        end else begin
          if (slot_total[hit_slot] != it_total) begin
            slot_used[hit_slot] <= 1'b0;
            batch_discard       <= ffr_pkg::STAT_INCONSISTENT;
          end
          batch_slot <= hit_slot;
        end
      end
      if (cmd.ent) begin
        if (ent_ok) begin
          slot_bitmap[batch_slot][idx_lo] <= 1'b1;
          slot_count[batch_slot]          <= slot_count[batch_slot] + 7'd1;
        end
        if (it_end) begin
          batch_open <= 1'b0;
        end
      end
      if (cmd.finish) begin
        o_phase  <= '0;
        o_index  <= '0;
        o_vent   <= 1'b0;
        o_entity <= '0;
        o_last   <= 1'b1;
        if (batch_discard != ffr_pkg::STAT_PENDING) begin
          o_valid  <= 1'b1;
          o_status <= batch_discard;
          o_tick   <= it_tick;
        end else if (complete) begin
          for (int k = 0; k < ffr_pkg::NSLOTS; k++) begin
            if (slot_tick[k] <= slot_tick[batch_slot]) begin
              slot_used[k] <= 1'b0;
            end
          end
          newest_done_tick <= slot_tick[batch_slot];
          any_done         <= 1'b1;
          em_tick          <= slot_tick[batch_slot];
          em_phase         <= slot_phase[batch_slot];
          em_n             <= slot_total[batch_slot];
          em_slot          <= batch_slot;
          em_i             <= '0;
          if (slot_total[batch_slot] == 7'd0) begin
            o_valid  <= 1'b1;
            o_status <= ffr_pkg::STAT_COMPLETED;
            o_tick   <= slot_tick[batch_slot];
            o_phase  <= slot_phase[batch_slot];
          end
        end else begin
          // At most one slot over the limit can exist here.
          if ($countones(slot_used) > ffr_pkg::MAX_PENDING && old_found) begin
            slot_used[old_slot] <= 1'b0;
          end
          o_valid  <= 1'b1;
          o_status <= ffr_pkg::STAT_PENDING;
          o_tick   <= slot_tick[batch_slot];
        end
      end
      if (cmd.emit) begin
        o_valid  <= 1'b1;
        o_status <= ffr_pkg::STAT_COMPLETED;
        o_tick   <= em_tick;
        o_phase  <= em_phase;
        o_index  <= em_i;
        o_vent   <= 1'b1;
        o_entity <= 64'(rd_data);
        o_last   <= sts.em_last;
        em_i     <= em_i + ffr_pkg::IDX_W'(1);
      end
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {2'b00, o_entity, o_index, o_phase, o_tick};
  assign m_tuser  = {o_vent, o_status};
  assign m_tlast  = o_last;

  `FFR_ASSERT_NOW(a_hdr_closed, cmd.hdr, !batch_open)
  `FFR_ASSERT_NOW(a_emit_in_range, cmd.emit, 7'(em_i) < em_n)
  `FFR_ASSERT_NEXT(a_discard_result, cmd.finish && batch_discard != ffr_pkg::STAT_PENDING,
                   o_valid && o_last && o_status == $past(batch_discard))

endmodule

>>> tb/fragment_frame_reassembler_tb.sv
// Self-checking testbench for the fragment frame reassembler, with a predictor and idle phases.
`timescale 1ns / 100ps

module fragment_frame_reassembler_tb;

  // One fragment item as it travels on the slave side.
  typedef struct packed {
    logic [31:0] tick;
    logic [6:0]  total;
    logic [7:0]  phase;
    logic [15:0] first;
    logic [5:0]  pos;
    logic        has;
    logic [63:0] word;
    logic        endb;
  } frag_t;

  // One result item as it should appear on the master side.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] tick;
    logic [7:0]  phase;
    logic [5:0]  index;
    logic        valid;
    logic [63:0] entity;
    logic        last;
  } frame_res_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ffr_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ffr_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [2:0] m_tuser;
  logic m_tlast;

  fragment_frame_reassembler dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Fragments waiting to be driven, and results the frames should produce.
  frag_t      frag_queue[$];
  frame_res_t result_queue[$];
  frag_t      cur_frag;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int taken_count = 0;
  int taken_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Shadow copy of the reassembler state.
  logic        sh_used[ffr_pkg::NSLOTS];
  logic [31:0] sh_tick[ffr_pkg::NSLOTS];
  logic [6:0]  sh_total[ffr_pkg::NSLOTS];
  logic [7:0]  sh_phase[ffr_pkg::NSLOTS];
  logic [6:0]  sh_count[ffr_pkg::NSLOTS];
  logic [63:0] sh_bitmap[ffr_pkg::NSLOTS];
  logic [63:0] sh_store[ffr_pkg::NSLOTS][ffr_pkg::MAX_ENTITIES];
  logic [31:0] newest_done;
  logic        done_seen;
  logic        in_batch;
  logic [1:0]  drop_code;
  int          open_slot;

  initial begin
    for (int s = 0; s < ffr_pkg::NSLOTS; s++) begin
      sh_used[s] = 1'b0;
      sh_tick[s] = '0;
      sh_total[s] = '0;
      sh_phase[s] = '0;
      sh_count[s] = '0;
      sh_bitmap[s] = '0;
    end
    newest_done = '0;
    done_seen = 1'b0;
    in_batch = 1'b0;
    drop_code = ffr_pkg::STAT_PENDING;
    open_slot = 0;
  end

  function automatic int find_tick(logic [31:0] t);
    for (int s = 0; s < ffr_pkg::NSLOTS; s++)
      if (sh_used[s] && sh_tick[s] == t) return s;
    return -1;
  endfunction

  function automatic int open_count();
    int n;
    n = 0;
    for (int s = 0; s < ffr_pkg::NSLOTS; s++) n += sh_used[s];
    return n;
  endfunction

  task automatic queue_result(logic [1:0] st, logic [31:0] t, logic [7:0] ph,
                              logic [5:0] ix, logic v, logic [63:0] e, logic l);
    frame_res_t r;
    r.status = st; r.tick = t; r.phase = ph; r.index = ix;
    r.valid = v; r.entity = e; r.last = l;
    result_queue.insert(result_queue.size(), r);
  endtask

  // Advance the shadow state by one accepted fragment and queue its results.
  task automatic reassemble_frag(frag_t f);
    int sl;
    int old;
    logic [16:0] idx;
    logic [31:0] done_tick;
    if (!in_batch) begin
      in_batch = 1'b1;
      drop_code = ffr_pkg::STAT_PENDING;
      sl = find_tick(f.tick);
      if (done_seen && f.tick <= newest_done) begin
        // Stale batch: forget any leftover slot of this tick.
        if (sl >= 0) sh_used[sl] = 1'b0;
        drop_code = ffr_pkg::STAT_STALE;
      end else begin
        if (sl < 0) begin
          sl = 0;
          for (int k = ffr_pkg::NSLOTS - 1; k >= 0; k--)
            if (!sh_used[k]) sl = k;
          sh_used[sl] = 1'b1;
          sh_tick[sl] = f.tick;
          sh_total[sl] = f.total;
          sh_phase[sl] = f.phase;
          sh_count[sl] = '0;
          sh_bitmap[sl] = '0;
        end else if (sh_total[sl] != f.total) begin
          sh_used[sl] = 1'b0;
          drop_code = ffr_pkg::STAT_INCONSISTENT;
        end
        open_slot = sl;
      end
    end
    sl = open_slot;
    if (drop_code == ffr_pkg::STAT_PENDING && f.has) begin
      idx = {1'b0, f.first} + {11'd0, f.pos};
      if (idx < sh_total[sl] && idx < ffr_pkg::MAX_ENTITIES && !sh_bitmap[sl][idx[5:0]]) begin
        sh_bitmap[sl][idx[5:0]] = 1'b1;
        sh_store[sl][idx[5:0]] = f.word;
        sh_count[sl] = sh_count[sl] + 7'd1;
      end
    end
    if (!f.endb) return;
    in_batch = 1'b0;
    if (drop_code != ffr_pkg::STAT_PENDING) begin
      queue_result(drop_code, f.tick, '0, '0, 1'b0, '0, 1'b1);
    end else if (sh_count[sl] >= sh_total[sl]) begin
      done_tick = sh_tick[sl];
      if (sh_total[sl] == 0)
        queue_result(ffr_pkg::STAT_COMPLETED, done_tick, sh_phase[sl], '0, 1'b0, '0, 1'b1);
      else
        for (int i = 0; i < sh_total[sl] && i < ffr_pkg::MAX_ENTITIES; i++)
          queue_result(ffr_pkg::STAT_COMPLETED, done_tick, sh_phase[sl], i[5:0], 1'b1,
                       sh_store[sl][i], i + 1 == sh_total[sl]);
      // A completed frame retires itself and every older frame.
      for (int k = 0; k < ffr_pkg::NSLOTS; k++)
        if (sh_used[k] && sh_tick[k] <= done_tick) sh_used[k] = 1'b0;
      newest_done = done_tick;
      done_seen = 1'b1;
    end else begin
      done_tick = sh_tick[sl];
      // Too many open frames: drop the oldest, possibly this one.
      while (open_count() > ffr_pkg::MAX_PENDING) begin
        old = -1;
        for (int k = 0; k < ffr_pkg::NSLOTS; k++)
          if (sh_used[k] && (old < 0 || sh_tick[k] < sh_tick[old])) old = k;
        sh_used[old] = 1'b0;
      end
      queue_result(ffr_pkg::STAT_PENDING, done_tick, '0, '0, 1'b0, '0, 1'b1);
    end
  endtask

  task automatic push_frag(logic [31:0] t, logic [6:0] tot, logic [7:0] ph,
                           logic [15:0] fi, logic [5:0] p, logic h, logic e);
    frag_t f;
    f.tick = t; f.total = tot; f.phase = ph; f.first = fi; f.pos = p;
    f.has = h; f.word = {$urandom, $urandom}; f.endb = e;
    frag_queue.insert(frag_queue.size(), f);
  endtask

  // One batch of n entities at positions 0..n-1; later items may carry a
  // scrambled header, which the block must ignore, and the odd repeat.
  task automatic push_batch(logic [31:0] t, logic [6:0] tot, logic [7:0] ph,
                            logic [15:0] fi, int n);
    logic [31:0] ht;
    logic [5:0]  p;
    for (int i = 0; i < n; i++) begin
      ht = t;
      p = i[5:0];
      if (i > 0 && $urandom_range(0, 3) == 0) ht = $urandom;
      if (i > 0 && $urandom_range(0, 9) == 0) p = p - 6'd1;
      // The end item's tick is only seen on a dropped batch, so keep it right.
      if (i == n - 1) ht = t;
      push_frag(ht, (i > 0 && ht != t) ? 7'($urandom) : tot, 8'($urandom), fi, p, 1'b1,
                i == n - 1);
    end
  endtask

  // A whole frame in chunks of random size; with gaps some chunks are skipped at random, so the frame can stay open.
  task automatic push_frame(logic [31:0] t, int tot, bit gaps);
    int i;
    int n;
    logic [7:0] ph;
    ph = 8'($urandom);
    if (tot == 0) begin
      push_frag(t, 7'd0, ph, 16'($urandom), 6'($urandom), 1'b0, 1'b1);
      return;
    end
    i = 0;
    while (i < tot) begin
      n = $urandom_range(1, (tot - i) < 8 ? tot - i : 8);
      if (!(gaps && $urandom_range(0, 2) == 0)) push_batch(t, tot[6:0], ph, i[15:0], n);
      i += n;
    end
  endtask

  // Sender: a new fragment is presented at the falling edge after a handshake.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || taken_count != taken_seen)) begin
      taken_seen = taken_count;
      if (frag_queue.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        cur_frag = frag_queue[0];
        frag_queue.delete(0);
        s_tdata <= {4'd0, cur_frag.word, cur_frag.pos, cur_frag.first, cur_frag.phase,
                    cur_frag.total, cur_frag.tick};
        s_tuser <= cur_frag.has;
        s_tlast <= cur_frag.endb;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    if (!rst) m_tready <= $urandom_range(1, 100) > recv_stall_pct;
  end

  // Acceptance, prediction and checking, all at the rising edge.
  always @(posedge clk) begin
    frame_res_t exp_res;
    frame_res_t got;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fragment_frame_reassembler: mismatch");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) begin
        reassemble_frag(cur_frag);
        taken_count = taken_count + 1;
      end
      if (m_tvalid && m_tready) begin
        got.tick = m_tdata[31:0];
        got.phase = m_tdata[39:32];
        got.index = m_tdata[45:40];
        got.entity = m_tdata[109:46];
        got.status = m_tuser[1:0];
        got.valid = m_tuser[2];
        got.last = m_tlast;
        if (result_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: status %0d tick %h", got.status, got.tick);
        end else begin
          exp_res = result_queue[0];
          result_queue.delete(0);
          if (got !== exp_res) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result differs: exp st %0d tick %h ph %h ix %0d v %b ent %h l %b",
                       exp_res.status, exp_res.tick, exp_res.phase, exp_res.index,
                       exp_res.valid, exp_res.entity, exp_res.last);
              $display("                got st %0d tick %h ph %h ix %0d v %b ent %h l %b",
                       got.status, got.tick, got.phase, got.index, got.valid,
                       got.entity, got.last);
            end
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (frag_queue.size() > 0 || s_tvalid) @(posedge clk);
  endtask

  initial begin
    logic [31:0] base;
    int pushed;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. An empty frame completes with one result.
    push_frag(32'd10, 7'd0, 8'hA5, 16'hFFFF, 6'h3F, 1'b0, 1'b1);
    // Stale ticks, one below and one equal to the newest completed tick.
    push_frag(32'd5, 7'd3, 8'h00, 16'd0, 6'd0, 1'b1, 1'b1);
    push_frag(32'd10, 7'd1, 8'hFF, 16'd0, 6'd0, 1'b1, 1'b1);
    // Duplicate index keeps the first word; then a total mismatch drops it.
    push_frag(32'd20, 7'd3, 8'h11, 16'd0, 6'd0, 1'b1, 1'b0);
    push_frag(32'd20, 7'd3, 8'h11, 16'd0, 6'd0, 1'b1, 1'b1);
    push_frag(32'd20, 7'd4, 8'h11, 16'd1, 6'd0, 1'b1, 1'b1);
    // Out-of-range index skipped, then a header change on a later item.
    push_frag(32'd30, 7'd2, 8'h5A, 16'd0, 6'd0, 1'b1, 1'b0);
    push_frag(32'd31, 7'd99, 8'h00, 16'd0, 6'd5, 1'b1, 1'b1);
    push_frag(32'd30, 7'd2, 8'h77, 16'd1, 6'd0, 1'b1, 1'b1);
    // Six open frames force evictions, one of a frame too big to complete.
    push_frag(32'd45, 7'd2, 8'h01, 16'd0, 6'd0, 1'b1, 1'b1);
    push_frag(32'd41, 7'd100, 8'h02, 16'd63, 6'd0, 1'b1, 1'b1);
    push_frag(32'd42, 7'd2, 8'h03, 16'd0, 6'd0, 1'b1, 1'b1);
    push_frag(32'd43, 7'd2, 8'h04, 16'd0, 6'd0, 1'b1, 1'b1);
    push_frag(32'd44, 7'd2, 8'h05, 16'd0, 6'd0, 1'b1, 1'b1);
    push_frag(32'd40, 7'd2, 8'h06, 16'd0, 6'd0, 1'b1, 1'b1);
    push_frag(32'd40, 7'd2, 8'h06, 16'd1, 6'd0, 1'b0, 1'b1);
    push_frag(32'd44, 7'd2, 8'h05, 16'd1, 6'd0, 1'b1, 1'b1);
    push_frag(32'd42, 7'd2, 8'h03, 16'd1, 6'd0, 1'b1, 1'b1);
    push_frag(32'hFFFF_FFF0, 7'd64, 8'hC3, 16'hFFC0, 6'd63, 1'b1, 1'b1);
    wait_drained();

    // Random part in four idle phases, at least eighteen fragments each.
    base = 32'd1000 + $urandom_range(0, 32'h3FFF_FFFF);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 68 : 17) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 68 : 17) : 0;
      if (ph == 3) base = base | 32'h8000_0000;
      pushed = frag_queue.size();
      while (frag_queue.size() - pushed < 18) begin
        case ($urandom_range(0, 9))
          0: begin
            // Noise: a lone fragment with a random header.
            push_frag($urandom_range(0, 1) ? $urandom : base, 7'($urandom),
                      8'($urandom), 16'($urandom), 6'($urandom), 1'($urandom), 1'b1);
          end
          1: push_frame(base - $urandom_range(0, 20), $urandom_range(0, 6), 1'b0);
          2: push_frame(base + $urandom_range(1, 8), $urandom_range(1, 10), 1'b1);
          default: begin
            base = base + $urandom_range(1, 3);
            push_frame(base, $urandom_range(0, 12), $urandom_range(0, 3) == 0);
          end
        endcase
      end
      if (ph == 3) begin
        base = base + 32'd1;
        push_frame(base, 64, 1'b0);
      end
      wait_drained();
    end

    while (result_queue.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fragment_frame_reassembler: match");
    end else begin
      $display("fragment_frame_reassembler: mismatch");
    end
    $finish;
  end

endmodule
